// File: hdl/sle_pkg.sv
// Shared types and codes for the positional list engine.
`default_nettype none

package sle_pkg;

	// Request operation codes
	typedef enum logic [2:0] {
		OP_INSERT = 3'd0,
		OP_REMOVE = 3'd1,
		OP_READ   = 3'd2,
		OP_WRITE  = 3'd3,
		OP_SEARCH = 3'd4
	} sle_op_t;

	// Command broadcast to every cell of the chain
	typedef enum logic [2:0] {
		CELL_IDLE,
		CELL_INSERT,
		CELL_REMOVE,
		CELL_WRITE,
		CELL_READ,
		CELL_SEARCH
	} sle_cell_op_t;

	// Per-cell status captured with the request beat
	typedef struct packed {
		logic hit; // entry is live and equals the search value
		logic sel; // entry is the one addressed by a read
	} sle_flag_t;

	typedef enum logic {
		ST_IDLE,
		ST_RESP
	} sle_state_t;

endpackage : sle_pkg

`default_nettype wire

// File: hdl/sle_ifs.sv
// Valid/ready channel interfaces for requests and responses.
`default_nettype none

interface sle_req_if;
	logic               valid;
	logic               ready;
	logic        [2:0]  op;
	logic        [6:0]  position;
	logic signed [31:0] value;

	modport source (output valid, output op, output position, output value, input ready);
	modport sink   (input valid, input op, input position, input value, output ready);
endinterface : sle_req_if

interface sle_rsp_if;
	logic               valid;
	logic               ready;
	logic               accepted;
	logic signed [31:0] read_value;
	logic        [6:0]  found_position;
	logic        [6:0]  list_length;
	logic               is_empty;
	logic               is_full;

	modport source (output valid, output accepted, output read_value, output found_position,
		output list_length, output is_empty, output is_full, input ready);
	modport sink   (input valid, input accepted, input read_value, input found_position,
		input list_length, input is_empty, input is_full, output ready);
endinterface : sle_rsp_if

`default_nettype wire

// File: hdl/sequential_list_engine.sv
// Top level of the positional list engine: request decode, cell chain, response register.
//
// Usage
//   req  : request beats (op, 1-based position, value), valid/ready.
//   rsp  : one response beat per request (accepted, read_value,
//          found_position, list_length, is_empty, is_full), valid/ready.
//   cfg  : cfg_we/cfg_wdata write capacity_limit; write only while idle.
// Timing
//   A request beat updates every cell of the chain at once on the edge it
//   is taken (shift up, shift down, overwrite) and latches per-cell hit and
//   select flags. Those flags are folded into the response register once
//   any response still waiting on rsp has been taken (rsp_load).
//   The accept/respond two-state controller takes no new request until
//   the response of the previous request has been loaded.
// Stall
//   A new request is taken while a finished response still waits on rsp;
//   the following response is held back until the waiting one is taken.
// Reset
//   arst_n clears the length, the flags and the controller and sets
//   capacity_limit to its default; entry contents are left as they are
//   and are never visible before being written.
`default_nettype none

module sequential_list_engine
	import sle_pkg::*;
#(
	parameter int CAPACITY   = 64,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	sle_req_if.sink         req,
	sle_rsp_if.source       rsp,
	input  wire logic       cfg_we,
	input  wire logic [6:0] cfg_wdata
);

	// Length counter width and a compare width that covers positions too
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = ((CW > 7) ? CW : 7) + 1;
	localparam logic [PW-1:0] CAP_X = PW'(CAPACITY);
	localparam logic [6:0] LIMIT_RESET = 7'd64;

	// ---------------- state ----------------
	sle_state_t    state_q, state_d;
	logic [CW-1:0] count_q;
	logic [6:0]    limit_q;
	logic          acc_s1;
	sle_cell_op_t  kind_s1;   // what the last taken beat did to the chain

	logic          rsp_valid_q;
	logic          acc_q;
	logic [31:0]   rd_q;
	logic [6:0]    found_q;
	logic [6:0]    len_q;
	logic          empty_q;
	logic          full_q;

	// ---------------- controller outputs ----------------
	logic req_ready;
	logic rsp_load;
	logic req_fire;

	assign req_fire = req.valid && req_ready;

	// ---------------- request decode ----------------
	logic [PW-1:0] pos_x;
	logic [PW-1:0] cnt_x;
	logic [PW-1:0] lim_x;
	logic          in_range;
	logic          ins_ok;
	logic          req_ok;
	sle_cell_op_t  req_kind;
	sle_cell_op_t  cell_kind;

	assign pos_x = PW'(req.position);
	assign cnt_x = PW'(count_q);
	// a limit above the built capacity counts as the capacity
	assign lim_x = (PW'(limit_q) > CAP_X) ? CAP_X : PW'(limit_q);

	assign in_range = (pos_x != '0) && (pos_x <= cnt_x);
	assign ins_ok   = (cnt_x < lim_x) && (pos_x != '0) && (pos_x <= cnt_x + PW'(1));

	always_comb begin
		req_ok   = 1'b0;
		req_kind = CELL_IDLE;
		unique case (req.op)
			OP_INSERT: begin
				req_ok   = ins_ok;
				req_kind = ins_ok ? CELL_INSERT : CELL_IDLE;
			end
			OP_REMOVE: begin
				req_ok   = in_range;
				req_kind = in_range ? CELL_REMOVE : CELL_IDLE;
			end
			OP_READ: begin
				req_ok   = in_range;
				req_kind = in_range ? CELL_READ : CELL_IDLE;
			end
			OP_WRITE: begin
				req_ok   = in_range;
				req_kind = in_range ? CELL_WRITE : CELL_IDLE;
			end
			OP_SEARCH: begin
				req_ok   = 1'b1;
				req_kind = CELL_SEARCH;
			end
			default: begin
				// unused codes: nothing changes, status still reported
				req_ok   = 1'b0;
				req_kind = CELL_IDLE;
			end
		endcase
	end

	assign cell_kind = req_fire ? req_kind : CELL_IDLE;

	// search compares against the value cut (or zero-padded) to the entry width
	logic [DATA_WIDTH-1:0] val_w;
	assign val_w = DATA_WIDTH'($unsigned(req.value));

	// ---------------- cell chain ----------------
	logic      [DATA_WIDTH-1:0] cell_data [CAPACITY];
	sle_flag_t                  cell_flag [CAPACITY];
	logic      [CAPACITY-1:0]   hit_vec;
	logic      [CAPACITY-1:0]   sel_vec;

	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_d;
		logic [DATA_WIDTH-1:0] right_d;

		if (k == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_mid_l
			assign left_d = cell_data[k-1];
		end

		if (k == CAPACITY - 1) begin : g_last
			assign right_d = cell_data[k];
		end else begin : g_mid_r
			assign right_d = cell_data[k+1];
		end

		sle_cell #(
			.DATA_WIDTH (DATA_WIDTH),
			.IDX        (k),
			.PW         (PW)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.kind       (cell_kind),
			.pos        (pos_x),
			.cnt        (cnt_x),
			.val        (val_w),
			.left_data  (left_d),
			.right_data (right_d),
			.data       (cell_data[k]),
			.flags      (cell_flag[k])
		);

		assign hit_vec[k] = cell_flag[k].hit;
		assign sel_vec[k] = cell_flag[k].sel;
	end

	// ---------------- result fold ----------------
	// lowest set hit bit marks the first match
	logic        [CAPACITY-1:0]   first_hit;
	logic        [6:0]            found_pos;
	logic signed [DATA_WIDTH-1:0] rd_or;

	assign first_hit = hit_vec & (~hit_vec + {{(CAPACITY-1){1'b0}}, 1'b1});

	always_comb begin
		found_pos = '0;
		rd_or     = '0;
		for (int k = 0; k < CAPACITY; k++) begin
			if (first_hit[k]) begin
				found_pos = found_pos | 7'(k + 1);
			end
			if (sel_vec[k]) begin
				rd_or = rd_or | cell_data[k];
			end
		end
	end

	// ---------------- controller ----------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (rsp_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		rsp_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
			end
			ST_RESP: begin
				rsp_load = !rsp_valid_q || rsp.ready;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			limit_q     <= LIMIT_RESET;
			acc_s1      <= 1'b0;
			kind_s1     <= CELL_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (req_fire) begin
				acc_s1  <= req_ok;
				kind_s1 <= req_kind;
				if (req_kind == CELL_INSERT) begin
					count_q <= CW'(count_q + 1'b1);
				end else if (req_kind == CELL_REMOVE) begin
					count_q <= CW'(count_q - 1'b1);
				end
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// response payload; refused beats leave the cell flags as they were,
	// so read data and match position only count for their own op
	always_ff @(posedge clk) begin
		if (rsp_load) begin
			acc_q   <= acc_s1;
			rd_q    <= (kind_s1 == CELL_READ) ? 32'(rd_or) : '0;
			found_q <= (kind_s1 == CELL_SEARCH) ? found_pos : '0;
			len_q   <= 7'(count_q);
			empty_q <= (count_q == '0);
			full_q  <= (cnt_x >= lim_x);
		end
	end

	assign req.ready          = req_ready;
	assign rsp.valid          = rsp_valid_q;
	assign rsp.accepted       = acc_q;
	assign rsp.read_value     = rd_q;
	assign rsp.found_position = found_q;
	assign rsp.list_length    = len_q;
	assign rsp.is_empty       = empty_q;
	assign rsp.is_full        = full_q;

	// ---------------- assertions ----------------
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_x <= CAP_X)
		else $error("list length beyond capacity");

	a_read_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(sel_vec))
		else $error("more than one cell selected for read");

	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!req_fire |=> $stable(count_q))
		else $error("length changed without a request beat");

	a_fire_to_resp: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> (state_q == ST_RESP))
		else $error("request beat not followed by response phase");

	a_no_hit_no_found: assert property (@(posedge clk) disable iff (!arst_n)
		(hit_vec == '0) |-> (found_pos == '0))
		else $error("found position without a hit");

endmodule : sequential_list_engine

`default_nettype wire

// File: hdl/sle_cell.sv
// One list slot: holds an entry, shifts with its neighbors, flags hits.
`default_nettype none

module sle_cell
	import sle_pkg::*;
#(
	parameter int DATA_WIDTH = 32,
	parameter int IDX        = 0,
	parameter int PW         = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire sle_cell_op_t          kind,
	input  wire logic [PW-1:0]         pos,
	input  wire logic [PW-1:0]         cnt,
	input  wire logic [DATA_WIDTH-1:0] val,
	input  wire logic [DATA_WIDTH-1:0] left_data,
	input  wire logic [DATA_WIDTH-1:0] right_data,
	output logic      [DATA_WIDTH-1:0] data,
	output sle_flag_t                  flags
);

	// 1-based position of this slot
	localparam logic [PW-1:0] POS_K = PW'(IDX + 1);

	logic [DATA_WIDTH-1:0] data_q;
	sle_flag_t             flag_s1;
	logic                  at_pos;
	logic                  past_pos;

	assign at_pos   = (POS_K == pos);
	assign past_pos = (POS_K > pos);

	always_ff @(posedge clk) begin
		case (kind)
			CELL_INSERT: begin
				if (past_pos) begin
					data_q <= left_data;
				end else if (at_pos) begin
					data_q <= val;
				end
			end
			CELL_REMOVE: begin
				if (past_pos || at_pos) begin
					data_q <= right_data;
				end
			end
			CELL_WRITE: begin
				if (at_pos) begin
					data_q <= val;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_s1 <= '0;
		end else if (kind != CELL_IDLE) begin
			flag_s1.hit <= (kind == CELL_SEARCH) && (data_q == val) && (POS_K <= cnt);
			flag_s1.sel <= (kind == CELL_READ) && at_pos;
		end
	end

	assign data  = data_q;
	assign flags = flag_s1;

endmodule : sle_cell

`default_nettype wire
